// ===== design/gtl_pkg.sv =====
// ============================================================================
// gtl_pkg
// Shared types, constants and the lunar year table for the Gregorian to
// lunar date converter.
// ============================================================================
package gtl_pkg;

    // Table span and first year of the table
    localparam int DEFINED_YEARS   = 100;
    localparam int TABLE_YEARS_DEF = 100;
    localparam int BASE_YEAR       = 1921;

    // Field widths
    localparam int YEAR_W  = 11;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int IDX_W   = 4;
    localparam int WORD_W  = 20;
    localparam int COUNT_W = 17;
    localparam int TIDX_W  = $clog2(DEFINED_YEARS);

    // Day count offset: new year of 1921 falls on day 39 of that year
    localparam int NY_OFFSET = 38;
    // Words at or above this value carry thirteen months
    localparam logic [WORD_W-1:0] LEAP_WORD_MIN = 20'd4095;

    // Stem and branch of the first table year: (1921 - 4) mod 10 and mod 12
    localparam logic [IDX_W-1:0] STEM_BASE   = 4'd7;
    localparam logic [IDX_W-1:0] BRANCH_BASE = 4'd9;
    localparam logic [IDX_W-1:0] STEM_LAST   = 4'd9;
    localparam logic [IDX_W-1:0] BRANCH_LAST = 4'd11;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WALK
    } t_state;

    // One word per lunar year: month length bits, first month highest,
    // leap month position in bits 19..16
    localparam logic [WORD_W-1:0] LUNAR_TABLE [DEFINED_YEARS] = '{
        20'd2635,   20'd333387, 20'd1701,   20'd1748,   20'd267701,
        20'd694,    20'd2391,   20'd133423, 20'd1175,   20'd396438,
        20'd3402,   20'd3749,   20'd331177, 20'd1453,   20'd694,
        20'd201326, 20'd2350,   20'd465197, 20'd3221,   20'd3402,
        20'd400202, 20'd2901,   20'd1386,   20'd267611, 20'd605,
        20'd2349,   20'd137515, 20'd2709,   20'd464533, 20'd1738,
        20'd2901,   20'd330421, 20'd1242,   20'd2651,   20'd199255,
        20'd1323,   20'd529706, 20'd3733,   20'd1706,   20'd398762,
        20'd2741,   20'd1206,   20'd267438, 20'd2647,   20'd1318,
        20'd204070, 20'd3477,   20'd461653, 20'd1386,   20'd2413,
        20'd330077, 20'd1197,   20'd2637,   20'd268877, 20'd3365,
        20'd531109, 20'd2900,   20'd2922,   20'd398042, 20'd2395,
        20'd1179,   20'd267415, 20'd2635,   20'd661067, 20'd1701,
        20'd1748,   20'd398772, 20'd2742,   20'd2391,   20'd330031,
        20'd1175,   20'd1611,   20'd200010, 20'd3749,   20'd527717,
        20'd1452,   20'd2742,   20'd332397, 20'd2350,   20'd3222,
        20'd268949, 20'd3402,   20'd3493,   20'd133973, 20'd1386,
        20'd464219, 20'd605,    20'd2349,   20'd334123, 20'd2709,
        20'd2890,   20'd267946, 20'd2773,   20'd592565, 20'd1210,
        20'd2651,   20'd395863, 20'd1323,   20'd2707,   20'd265877
    };

    // Days in the common year before the first of each month
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/gregorian_to_lunar_date.sv =====
// ============================================================================
// gregorian_to_lunar_date
// Converts a Gregorian date to the Chinese lunar date by walking a lunar
// year table held in a synchronous ROM, one month per cycle outside ROM fetches.
// ============================================================================
//
//  Channel   Handshake           Signals
//  --------  ------------------  -------------------------------------------
//  command   i_start & !o_busy   i_greg_year, i_greg_month, i_greg_day
//  result    o_done (1 cycle)    o_date_valid, o_lunar_year, o_lunar_month,
//                                o_is_leap_month, o_lunar_day, o_stem_index,
//                                o_branch_index
//
//  A date checked out as invalid at the command beat returns in the next cycle.
//  Otherwise the walk steps one lunar month at a time, with a fetch state to read
//  the ROM on entering each table year; its length is set by the single-month step
//  on the table ROM's one read port.
//  Reset is synchronous, active low, and clears the controller and o_done.
//  The receiver cannot stall: each result beat is on the ports for one cycle.
//
module gregorian_to_lunar_date #(
    parameter int TABLE_YEARS = gtl_pkg::TABLE_YEARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [gtl_pkg::YEAR_W-1:0]    i_greg_year,
    input  logic [gtl_pkg::MONTH_W-1:0]   i_greg_month,
    input  logic [gtl_pkg::DAY_W-1:0]     i_greg_day,
    output logic                          o_done,
    output logic                          o_date_valid,
    output logic [gtl_pkg::YEAR_W-1:0]    o_lunar_year,
    output logic [gtl_pkg::MONTH_W-1:0]   o_lunar_month,
    output logic                          o_is_leap_month,
    output logic [gtl_pkg::DAY_W-1:0]     o_lunar_day,
    output logic [gtl_pkg::IDX_W-1:0]     o_stem_index,
    output logic [gtl_pkg::IDX_W-1:0]     o_branch_index
);
    import gtl_pkg::*;

    localparam int SPAN  = (TABLE_YEARS > DEFINED_YEARS) ? DEFINED_YEARS : TABLE_YEARS;
    localparam int ROW_W = (SPAN > 1) ? $clog2(SPAN) : 1;

    // Controller and walk state
    t_state                r_state, n_state;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [MONTH_W-1:0]    r_mon, n_mon;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]      r_stem, n_stem;
    logic [IDX_W-1:0]      r_branch, n_branch;

    // Result registers
    logic                  r_done, n_done;
    logic                  r_valid, n_valid;
    logic [YEAR_W-1:0]     r_lyear, n_lyear;
    logic [MONTH_W-1:0]    r_lmonth, n_lmonth;
    logic                  r_leap, n_leap;
    logic [DAY_W-1:0]      r_lday, n_lday;
    logic [IDX_W-1:0]      r_ostem, n_ostem;
    logic [IDX_W-1:0]      r_obranch, n_obranch;

    // Table ROM output
    logic [WORD_W-1:0]     r_word;

    // Command decode and day count
    logic                  accept;
    logic                  in_ok;
    logic [6:0]            dyear;
    logic [COUNT_W-1:0]    day_sum;
    logic                  leap_fix;

    // Walk datapath
    logic                  word_leap;
    logic [MONTH_W-1:0]    top;
    logic [MONTH_W-1:0]    bit_idx;
    logic [5:0]            mon_len;
    logic                  found;
    logic [MONTH_W:0]      mon_num;
    logic [MONTH_W:0]      leap_pos;

    assign accept = i_start && (r_state == ST_IDLE);

    // Form the day count, day 1 being 1 January 1921
    assign in_ok    = (i_greg_year >= YEAR_W'(BASE_YEAR)) && (i_greg_month != '0)
                   && (i_greg_month <= MONTH_W'(12)) && (i_greg_day != '0);
    assign dyear    = 7'(i_greg_year - YEAR_W'(BASE_YEAR));
    assign leap_fix = (i_greg_year[1:0] == 2'b00) && (i_greg_month > MONTH_W'(2));
    assign day_sum  = COUNT_W'(dyear) * COUNT_W'(9'd365) + COUNT_W'(dyear[6:2])
                    + COUNT_W'(i_greg_day) + COUNT_W'(days_before(i_greg_month))
                    + COUNT_W'(leap_fix);

    // Read the table word of the current row
    always_ff @(posedge i_clk) begin
        r_word <= LUNAR_TABLE[TIDX_W'(r_row)];
    end

    // Decode the current month from the table word
    assign word_leap = (r_word >= LEAP_WORD_MIN);
    assign top       = word_leap ? MONTH_W'(12) : MONTH_W'(11);
    assign bit_idx   = top - r_mon;
    assign mon_len   = 6'd29 + 6'(r_word[5'(bit_idx)]);
    assign found     = (r_count <= COUNT_W'(mon_len));
    assign mon_num   = (MONTH_W+1)'(r_mon) + 5'd1;
    assign leap_pos  = (MONTH_W+1)'(r_word[19:16]) + 5'd1;

    // Next state and results
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_mon     = r_mon;
        n_count   = r_count;
        n_stem    = r_stem;
        n_branch  = r_branch;
        n_done    = 1'b0;
        n_valid   = r_valid;
        n_lyear   = r_lyear;
        n_lmonth  = r_lmonth;
        n_leap    = r_leap;
        n_lday    = r_lday;
        n_ostem   = r_ostem;
        n_obranch = r_obranch;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_row    = '0;
                    n_mon    = '0;
                    n_stem   = STEM_BASE;
                    n_branch = BRANCH_BASE;
                    n_count  = day_sum - COUNT_W'(NY_OFFSET);
                    if (in_ok && (day_sum > COUNT_W'(NY_OFFSET))) begin
                        n_state = ST_FETCH;
                    end else begin
                        // Drop an out-of-range date at once
                        n_done    = 1'b1;
                        n_valid   = 1'b0;
                        n_lyear   = '0;
                        n_lmonth  = '0;
                        n_leap    = 1'b0;
                        n_lday    = '0;
                        n_ostem   = '0;
                        n_obranch = '0;
                    end
                end
            end
            ST_FETCH: begin
                // Wait out the ROM read latency
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (found) begin
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                    n_valid   = 1'b1;
                    n_lyear   = YEAR_W'(BASE_YEAR) + YEAR_W'(r_row);
                    n_lday    = r_count[DAY_W-1:0];
                    n_ostem   = r_stem;
                    n_obranch = r_branch;
                    n_leap    = 1'b0;
                    n_lmonth  = mon_num[MONTH_W-1:0];
                    if (word_leap && (mon_num == leap_pos)) begin
                        n_leap   = 1'b1;
                        n_lmonth = r_mon;
                    end else if (word_leap && (mon_num > leap_pos)) begin
                        n_lmonth = r_mon;
                    end
                end else begin
                    n_count = r_count - COUNT_W'(mon_len);
                    if (r_mon == top) begin
                        if (r_row == ROW_W'(SPAN - 1)) begin
                            // Ran off the table end
                            n_state   = ST_IDLE;
                            n_done    = 1'b1;
                            n_valid   = 1'b0;
                            n_lyear   = '0;
                            n_lmonth  = '0;
                            n_leap    = 1'b0;
                            n_lday    = '0;
                            n_ostem   = '0;
                            n_obranch = '0;
                        end else begin
                            // Advance to the next table year
                            n_state  = ST_FETCH;
                            n_row    = r_row + ROW_W'(1);
                            n_mon    = '0;
                            n_stem   = (r_stem == STEM_LAST) ? '0 : r_stem + IDX_W'(1);
                            n_branch = (r_branch == BRANCH_LAST) ? '0 : r_branch + IDX_W'(1);
                        end
                    end else begin
                        n_mon = r_mon + MONTH_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Walk and result payload
    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_mon     <= n_mon;
        r_count   <= n_count;
        r_stem    <= n_stem;
        r_branch  <= n_branch;
        r_valid   <= n_valid;
        r_lyear   <= n_lyear;
        r_lmonth  <= n_lmonth;
        r_leap    <= n_leap;
        r_lday    <= n_lday;
        r_ostem   <= n_ostem;
        r_obranch <= n_obranch;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_date_valid    = r_valid;
    assign o_lunar_year    = r_lyear;
    assign o_lunar_month   = r_lmonth;
    assign o_is_leap_month = r_leap;
    assign o_lunar_day     = r_lday;
    assign o_stem_index    = r_ostem;
    assign o_branch_index  = r_obranch;

`ifndef ASSERT_OFF
    // A result beat only comes with the controller back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result beat while busy");

    // A command beat either starts a walk or answers at once
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("command beat lost");

    // A valid result has a legal day and month
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_date_valid) |-> (o_lunar_day != '0) && (o_lunar_day <= 5'd30)
            && (o_lunar_month != '0) && (o_lunar_month <= 4'd12))
        else $error("valid result out of range");

    // An invalid result carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_date_valid) |-> (o_lunar_year == '0) && (o_lunar_month == '0)
            && !o_is_leap_month && (o_lunar_day == '0) && (o_stem_index == '0)
            && (o_branch_index == '0))
        else $error("invalid result not cleared");

    // Stem and branch stay in range during the walk
    a_cycle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_stem <= STEM_LAST) && (r_branch <= BRANCH_LAST))
        else $error("stem or branch counter out of range");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the Gregorian to lunar date converter. A directed
// table of dates covers the table edges, rejected fields and leap months.
// Random dates follow in phases of sender idling. Every result beat is compared
// field by field against its typed directed row or a local date conversion model.
// ============================================================================
module tb;

    // Local model constants
    localparam int FIRST_YEAR    = 1921;
    localparam int NEW_YEAR_SKEW = 38;
    localparam int ROW_COUNT     = 100;
    localparam int THIRTEEN_MIN  = 4095;

    // Walk length at the table end, used for the final drain
    localparam int DRAIN_CYCLES    = 1500;
    localparam int N_DIRECTED      = 23;
    localparam int N_PHASES        = 4;
    localparam int DATES_PER_PHASE = 105;
    localparam int TIMEOUT_NS      = 60_000_000;

    // One lunar year word per row: month lengths, first month highest bit,
    // leap month position in bits 19..16
    localparam logic [0:ROW_COUNT-1][19:0] YEAR_WORDS = {
        20'd2635,   20'd333387, 20'd1701,   20'd1748,   20'd267701,
        20'd694,    20'd2391,   20'd133423, 20'd1175,   20'd396438,
        20'd3402,   20'd3749,   20'd331177, 20'd1453,   20'd694,
        20'd201326, 20'd2350,   20'd465197, 20'd3221,   20'd3402,
        20'd400202, 20'd2901,   20'd1386,   20'd267611, 20'd605,
        20'd2349,   20'd137515, 20'd2709,   20'd464533, 20'd1738,
        20'd2901,   20'd330421, 20'd1242,   20'd2651,   20'd199255,
        20'd1323,   20'd529706, 20'd3733,   20'd1706,   20'd398762,
        20'd2741,   20'd1206,   20'd267438, 20'd2647,   20'd1318,
        20'd204070, 20'd3477,   20'd461653, 20'd1386,   20'd2413,
        20'd330077, 20'd1197,   20'd2637,   20'd268877, 20'd3365,
        20'd531109, 20'd2900,   20'd2922,   20'd398042, 20'd2395,
        20'd1179,   20'd267415, 20'd2635,   20'd661067, 20'd1701,
        20'd1748,   20'd398772, 20'd2742,   20'd2391,   20'd330031,
        20'd1175,   20'd1611,   20'd200010, 20'd3749,   20'd527717,
        20'd1452,   20'd2742,   20'd332397, 20'd2350,   20'd3222,
        20'd268949, 20'd3402,   20'd3493,   20'd133973, 20'd1386,
        20'd464219, 20'd605,    20'd2349,   20'd334123, 20'd2709,
        20'd2890,   20'd267946, 20'd2773,   20'd592565, 20'd1210,
        20'd2651,   20'd395863, 20'd1323,   20'd2707,   20'd265877
    };

    // Days of a common year ahead of each month
    localparam logic [0:11][8:0] MONTH_START = {
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Percent of cycles the sender sits idle, per random phase
    localparam logic [0:N_PHASES-1][6:0] PHASE_IDLE = {7'd0, 7'd70, 7'd19, 7'd0};

    typedef struct packed {
        logic                        valid;
        logic [gtl_pkg::YEAR_W-1:0]  year;
        logic [gtl_pkg::MONTH_W-1:0] month;
        logic                        leap;
        logic [gtl_pkg::DAY_W-1:0]   day;
        logic [gtl_pkg::IDX_W-1:0]   stem;
        logic [gtl_pkg::IDX_W-1:0]   branch;
    } t_lunar_date;

    typedef struct packed {
        logic [gtl_pkg::YEAR_W-1:0]  year;
        logic [gtl_pkg::MONTH_W-1:0] month;
        logic [gtl_pkg::DAY_W-1:0]   day;
        logic                        typed;
        t_lunar_date                 want;
    } t_date_row;

    localparam t_lunar_date NO_DATE   = '0;
    // Lunar 1921, first month, first day: stem 7, branch 9
    localparam t_lunar_date NEW_YEAR_1921 =
        {1'b1, 11'd1921, 4'd1, 1'b0, 5'd1, 4'd7, 4'd9};

    // Directed dates; rows with typed set carry their own expectation
    localparam t_date_row [0:N_DIRECTED-1] DIRECTED = {
        {11'd1921, 4'd2,  5'd8,  1'b1, NEW_YEAR_1921}, // lunar new year 1921
        {11'd1921, 4'd2,  5'd7,  1'b1, NO_DATE},       // eve of the table start
        {11'd1921, 4'd1,  5'd1,  1'b1, NO_DATE},
        {11'd1920, 4'd6,  5'd15, 1'b1, NO_DATE},       // year before the table
        {11'd0,    4'd1,  5'd1,  1'b1, NO_DATE},
        {11'd1990, 4'd0,  5'd10, 1'b1, NO_DATE},       // month zero
        {11'd1990, 4'd13, 5'd10, 1'b1, NO_DATE},
        {11'd1990, 4'd15, 5'd31, 1'b1, NO_DATE},
        {11'd1990, 4'd6,  5'd0,  1'b1, NO_DATE},       // day zero
        {11'd2047, 4'd12, 5'd31, 1'b1, NO_DATE},       // far past the table end
        {11'd2047, 4'd15, 5'd0,  1'b1, NO_DATE},
        {11'd2020, 4'd12, 5'd31, 1'b0, NO_DATE},
        {11'd2021, 4'd1,  5'd15, 1'b0, NO_DATE},       // last lunar year tail
        {11'd2021, 4'd6,  5'd1,  1'b0, NO_DATE},
        {11'd1922, 4'd7,  5'd25, 1'b0, NO_DATE},       // month after a leap month
        {11'd1921, 4'd2,  5'd31, 1'b0, NO_DATE},       // day past month end
        {11'd2000, 4'd2,  5'd29, 1'b0, NO_DATE},
        {11'd2000, 4'd3,  5'd1,  1'b0, NO_DATE},
        {11'd1984, 4'd2,  5'd2,  1'b0, NO_DATE},
        {11'd1921, 4'd12, 5'd31, 1'b0, NO_DATE},
        {11'd1958, 4'd10, 5'd31, 1'b0, NO_DATE},
        {11'd2020, 4'd1,  5'd25, 1'b0, NO_DATE},
        {11'd1921, 4'd3,  5'd10, 1'b0, NO_DATE}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic [gtl_pkg::YEAR_W-1:0]    i_greg_year = '0;
    logic [gtl_pkg::MONTH_W-1:0]   i_greg_month = '0;
    logic [gtl_pkg::DAY_W-1:0]     i_greg_day = '0;
    logic                          o_busy;
    logic                          o_done;
    logic                          o_date_valid;
    logic [gtl_pkg::YEAR_W-1:0]    o_lunar_year;
    logic [gtl_pkg::MONTH_W-1:0]   o_lunar_month;
    logic                          o_is_leap_month;
    logic [gtl_pkg::DAY_W-1:0]     o_lunar_day;
    logic [gtl_pkg::IDX_W-1:0]     o_stem_index;
    logic [gtl_pkg::IDX_W-1:0]     o_branch_index;

    t_lunar_date pending_dates [$];
    int          n_fail = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_in_span = 0;
    int          n_leap = 0;

    gregorian_to_lunar_date u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_greg_year    (i_greg_year),
        .i_greg_month   (i_greg_month),
        .i_greg_day     (i_greg_day),
        .o_done         (o_done),
        .o_date_valid   (o_date_valid),
        .o_lunar_year   (o_lunar_year),
        .o_lunar_month  (o_lunar_month),
        .o_is_leap_month(o_is_leap_month),
        .o_lunar_day    (o_lunar_day),
        .o_stem_index   (o_stem_index),
        .o_branch_index (o_branch_index)
    );

    always #10 i_clk = ~i_clk;

    // Convert one Gregorian date by walking the year words month by month
    function automatic t_lunar_date convert_date(input int y, input int m, input int d);
        t_lunar_date r;
        int          count;
        int          row;
        int          pos;
        int          top;
        int          len;
        int          lm;
        int          ly;
        int          leap_after;
        bit          found;
        logic [19:0] word;
        r = NO_DATE;
        if (y < FIRST_YEAR || m < 1 || m > 12 || d < 1) begin
            return r;
        end
        count = (y - FIRST_YEAR) * 365 + (y - FIRST_YEAR) / 4 + d
                + int'(MONTH_START[m - 1]) - NEW_YEAR_SKEW;
        if (y % 4 == 0 && m > 2) begin
            count = count + 1;
        end
        if (count < 1) begin
            return r;
        end
        found = 1'b0;
        row   = 0;
        pos   = 0;
        top   = 0;
        word  = '0;
        while (!found && row < ROW_COUNT) begin
            word = YEAR_WORDS[row];
            top  = (word < THIRTEEN_MIN) ? 11 : 12;
            pos  = top;
            while (!found && pos >= 0) begin
                len = 29 + int'(word[pos]);
                if (count <= len) begin
                    found = 1'b1;
                end else begin
                    count = count - len;
                    pos   = pos - 1;
                end
            end
            if (!found) begin
                row = row + 1;
            end
        end
        if (!found) begin
            return r;
        end
        ly = FIRST_YEAR + row;
        lm = top - pos + 1;
        // Flag the repeated month and fold it and the months after it back by one
        if (top == 12) begin
            leap_after = int'(word[19:16]);
            if (lm == leap_after + 1) begin
                r.leap = 1'b1;
                lm     = lm - 1;
            end else if (lm > leap_after + 1) begin
                lm = lm - 1;
            end
        end
        r.valid  = 1'b1;
        r.year   = 11'(ly);
        r.month  = 4'(lm);
        r.day    = 5'(count);
        r.stem   = 4'((ly - 4) % 10);
        r.branch = 4'((ly - 4) % 12);
        return r;
    endfunction

    // Present one date and hold it until the command beat is taken
    task automatic send_date(
        input logic [gtl_pkg::YEAR_W-1:0]  y,
        input logic [gtl_pkg::MONTH_W-1:0] m,
        input logic [gtl_pkg::DAY_W-1:0]   d,
        input logic                        typed,
        input t_lunar_date                 want,
        input int                          idle_pct
    );
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_greg_year  <= y;
        i_greg_month <= m;
        i_greg_day   <= d;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_dates.push_back(typed ? want : convert_date(y, m, d));
        n_sent = n_sent + 1;
    endtask

    // Drop start and wait out every outstanding result
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_dates.size() != 0);
    endtask

    // Compare each result beat with the oldest expected date
    always @(posedge i_clk) begin : check_results
        t_lunar_date got;
        t_lunar_date want;
        if (i_rst_n && o_done) begin
            got = {o_date_valid, o_lunar_year, o_lunar_month, o_is_leap_month,
                   o_lunar_day, o_stem_index, o_branch_index};
            n_results = n_results + 1;
            if (got.valid === 1'b1) n_in_span = n_in_span + 1;
            if (got.leap === 1'b1) n_leap = n_leap + 1;
            if (pending_dates.size() == 0) begin
                n_fail = n_fail + 1;
                if (n_fail <= 10) begin
                    $display("%0t: result beat with nothing expected", $time);
                end
            end else begin
                want = pending_dates.pop_front();
                if (got.valid !== want.valid || got.year !== want.year
                    || got.month !== want.month || got.leap !== want.leap
                    || got.day !== want.day || got.stem !== want.stem
                    || got.branch !== want.branch) begin
                    n_fail = n_fail + 1;
                    if (n_fail <= 10) begin
                        $display("%0t: mismatch valid/year/month/leap/day/stem/branch", $time);
                        $display("  want %0d %0d %0d %0d %0d %0d %0d", want.valid, want.year,
                                 want.month, want.leap, want.day, want.stem, want.branch);
                        $display("  got  %0d %0d %0d %0d %0d %0d %0d", got.valid, got.year,
                                 got.month, got.leap, got.day, got.stem, got.branch);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial begin
        int                          idx;
        int                          phase;
        int                          k;
        logic [gtl_pkg::YEAR_W-1:0]  y;
        logic [gtl_pkg::MONTH_W-1:0] m;
        logic [gtl_pkg::DAY_W-1:0]   d;
        t_date_row                   row;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < N_DIRECTED; idx++) begin
            row = DIRECTED[idx];
            send_date(row.year, row.month, row.day, row.typed, row.want, 0);
        end
        drain_results();

        for (phase = 0; phase < N_PHASES; phase++) begin
            for (k = 0; k < DATES_PER_PHASE; k++) begin
                idx = $urandom_range(99);
                if (idx < 88) begin
                    // Mostly well-formed dates, some near the table edges
                    m = 4'($urandom_range(12, 1));
                    d = 5'($urandom_range(31, 1));
                    if (idx < 75) begin
                        y = 11'($urandom_range(2020, 1921));
                    end else begin
                        case ($urandom_range(3))
                            0:       y = 11'd1920;
                            1:       y = 11'd1921;
                            2:       y = 11'd2020;
                            default: y = 11'd2021;
                        endcase
                    end
                end else begin
                    // Noise over the full field widths
                    y = 11'($urandom_range(2047));
                    m = 4'($urandom_range(15));
                    d = 5'($urandom_range(31));
                end
                send_date(y, m, d, 1'b0, NO_DATE, int'(PHASE_IDLE[phase]));
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_dates.size() != 0) begin
            n_fail = n_fail + pending_dates.size();
            $display("%0d expected dates never returned", pending_dates.size());
        end

        $display("sent %0d dates in %0d idle phases, %0d results back", n_sent, N_PHASES,
                 n_results);
        $display("%0d inside the table span, %0d in a leap month, %0d failures", n_in_span,
                 n_leap, n_fail);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout after %0d ns", TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
